### src/c3dc_pkg.sv
// Shared types and constants for the 3x3 convolution block.
// No dependencies.
package c3dc_pkg;
    localparam int PIX_W = 8;
    localparam int COEF_W = 8;
    localparam int PROD_W = 17;
    localparam int SUM_W = 21;
    localparam int DIV_W = 10;
    localparam int POS_W = 10;
    localparam int CFG_W = 24;
    localparam int IDX_W = 3;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [IDX_W-1:0] {
        REG_KROW0 = 3'd0,
        REG_KROW1 = 3'd1,
        REG_KROW2 = 3'd2,
        REG_DIV   = 3'd3,
        REG_WIDTH = 3'd4,
        REG_HEIGHT = 3'd5
    } reg_idx_t;

    // Result tag that travels with a word through the divider.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } tag_t;

    // Word moving along the divider cells.
    typedef struct packed {
        logic             vld;
        logic             neg;
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] quo;
        logic [DIV_W-1:0] dvs;
        tag_t             tag;
    } div_word_t;
endpackage

### src/c3dc_div_cell.sv
// One restoring-division cell: settles one quotient bit per cycle while en is high.
// Depends on c3dc_pkg.
module c3dc_div_cell import c3dc_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  div_word_t din,
    output div_word_t dout
);
    div_word_t dout_reg;
    logic [SUM_W+DIV_W-1:0] trial;
    logic [SUM_W-1:0] rem_next;
    logic [SUM_W-1:0] quo_next;

    always_comb begin
        trial = {{DIV_W{1'b0}}, din.rem} - ({{SUM_W{1'b0}}, din.dvs} << BIT);
        rem_next = din.rem;
        quo_next = din.quo;
        if (!trial[SUM_W+DIV_W-1]) begin
            rem_next = trial[SUM_W-1:0];
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.vld <= 1'b0;
        end else if (en) begin
            dout_reg.vld <= din.vld;
        end
        if (en) begin
            dout_reg.neg <= din.neg;
            dout_reg.rem <= rem_next;
            dout_reg.quo <= quo_next;
            dout_reg.dvs <= din.dvs;
            dout_reg.tag <= din.tag;
        end
    end

    assign dout = dout_reg;
endmodule

### src/c3dc_window.sv
// Line stores, 3x3 window, position counters and registered weighted sum.
// Depends on c3dc_pkg.
module c3dc_window import c3dc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [PIX_W-1:0]        pixel,
    input  logic [3*CFG_W-1:0]      kernel,
    input  logic [10:0]             width,
    input  logic [10:0]             height,
    output logic                    sum_vld,
    output logic signed [SUM_W-1:0] sum,
    output tag_t                    sum_tag
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW > POS_W) ? AW + 1 : POS_W + 1;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] win_reg [3][3];
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [POS_W:0] row_reg;
    logic [CW-1:0] w_eff;
    logic [POS_W:0] h_eff;
    logic [AW-1:0] idx;
    logic [AW-1:0] rd_addr;
    logic [2*PIX_W-1:0] rd_reg;
    logic row_end, frame_end, produce;
    logic stg_vld_reg;
    tag_t stg_tag_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic prd_vld_reg;
    tag_t prd_tag_reg;
    logic sum_vld_reg;
    logic signed [SUM_W-1:0] sum_reg;
    tag_t sum_tag_reg;
    logic signed [SUM_W-1:0] acc;

    always_comb begin
        if (width < 11'd3) w_eff = CW'(3);
        else if (CW'(width) > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(width);
        if (height < 11'd3) h_eff = 11'd3;
        else if (height > 11'd1024) h_eff = 11'd1024;
        else h_eff = height;
    end

    assign idx = col_reg[AW-1:0];
    assign row_end = col_reg >= w_eff - CW'(1);
    assign frame_end = row_end && (row_reg >= h_eff - 11'd1);
    assign produce = (row_reg >= 11'd2) && (col_reg >= CW'(2));
    assign col_next = row_end ? '0 : col_reg + CW'(1);

    // Fetch the next column's pair ahead so it is registered when that word arrives.
    assign rd_addr = (aresetn && en && in_vld) ? col_next[AW-1:0] : idx;

    always_ff @(posedge aclk) begin
        if (en && in_vld) begin
            line_mem[idx] <= {rd_reg[PIX_W-1:0], pixel};
        end
        rd_reg <= line_mem[rd_addr];
    end

    // Window shifts left; column 2 takes top, mid, new pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            stg_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end else if (en) begin
            stg_vld_reg <= in_vld && produce;
            sum_vld_reg <= prd_vld_reg;
            if (in_vld) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_reg[2*PIX_W-1:PIX_W];
                win_reg[1][2] <= rd_reg[PIX_W-1:0];
                win_reg[2][2] <= pixel;
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + 11'd1;
                end else begin
                    col_reg <= col_next;
                end
            end
        end
    end

    // The window lags the counters by one word, so tags are taken here.
    always_ff @(posedge aclk) begin
        if (en && in_vld) begin
            stg_tag_reg.row <= POS_W'(row_reg - 11'd1);
            stg_tag_reg.col <= POS_W'(col_reg - CW'(1));
            stg_tag_reg.last <= frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[3*r+c] <= PROD_W'(
                        $signed(kernel[r*CFG_W + c*COEF_W +: COEF_W])
                        * $signed({1'b0, win_reg[r][c]}));
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < 9; i++)
            acc = acc + SUM_W'(prod_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= acc;
            sum_tag_reg <= prd_tag_reg;
        end
    end

    // Products are registered from the updated window; their valid and tag follow the stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) prd_vld_reg <= 1'b0;
        else if (en) prd_vld_reg <= stg_vld_reg;
        if (en) prd_tag_reg <= stg_tag_reg;
    end

    assign sum_vld = sum_vld_reg;
    assign sum = sum_reg;
    assign sum_tag = sum_tag_reg;
endmodule

### src/conv3x3_divide_clamp.sv
// 3x3 convolution with truncating divide and clamp, top level.
// Depends on c3dc_pkg, c3dc_window, c3dc_div_cell.
//
// Pixels stream in raster order, one per clock when the output is not stalled;
// each interior pixel's word passes the window, products, sum, sign fix,
// one divider cell per quotient bit and clamp. The whole pipeline
// advances together, so a word left unclaimed at the output (m_ready low)
// stalls every stage and s_ready. Border pixels give no word.
module conv3x3_divide_clamp import c3dc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PIX_W-1:0]  s_pixel,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_out_pixel,
    output logic [POS_W-1:0]  m_out_row,
    output logic [POS_W-1:0]  m_out_col,
    output logic              m_frame_done
);
    logic [3*CFG_W-1:0] kernel_reg;
    logic [DIV_W-1:0] div_reg;
    logic [10:0] width_reg, height_reg;
    logic en;
    logic sum_vld;
    logic signed [SUM_W-1:0] sum;
    tag_t sum_tag;
    div_word_t chain [SUM_W+1];
    div_word_t head_reg;
    logic out_vld_reg;
    logic [PIX_W-1:0] out_pix_reg;
    tag_t out_tag_reg;
    logic [SUM_W-1:0] q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= '0;
            div_reg <= DIV_W'(1);
            width_reg <= 11'd1024;
            height_reg <= 11'd1024;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KROW0: kernel_reg[0*CFG_W +: CFG_W] <= cfg_data;
                REG_KROW1: kernel_reg[1*CFG_W +: CFG_W] <= cfg_data;
                REG_KROW2: kernel_reg[2*CFG_W +: CFG_W] <= cfg_data;
                REG_DIV: div_reg <= cfg_data[DIV_W-1:0];
                REG_WIDTH: width_reg <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless a word sits unclaimed at the output.
    assign en = !out_vld_reg || m_ready;
    assign s_ready = en;

    c3dc_window #(.MAX_WIDTH(MAX_WIDTH)) u_win (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(s_valid),
        .pixel(s_pixel), .kernel(kernel_reg), .width(width_reg),
        .height(height_reg), .sum_vld(sum_vld), .sum(sum), .sum_tag(sum_tag)
    );

    // Divide the magnitude; a negative sum is clamped to zero after the last cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) head_reg.vld <= 1'b0;
        else if (en) head_reg.vld <= sum_vld;
        if (en) begin
            head_reg.neg <= sum[SUM_W-1];
            head_reg.rem <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            head_reg.quo <= '0;
            head_reg.dvs <= (div_reg == '0) ? DIV_W'(1) : div_reg;
            head_reg.tag <= sum_tag;
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < SUM_W; i++) begin : g_cell
        c3dc_div_cell #(.BIT(SUM_W-1-i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .din(chain[i]), .dout(chain[i+1])
        );
    end

    assign q = chain[SUM_W].quo;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= chain[SUM_W].vld;
        if (en) begin
            if (chain[SUM_W].neg) out_pix_reg <= '0;
            else if (q > SUM_W'(PIX_MAX)) out_pix_reg <= PIX_MAX;
            else out_pix_reg <= q[PIX_W-1:0];
            out_tag_reg <= chain[SUM_W].tag;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_out_pixel = out_pix_reg;
    assign m_out_row = out_tag_reg.row;
    assign m_out_col = out_tag_reg.col;
    assign m_frame_done = out_tag_reg.last;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_pixel))
        else $error("output word changed while stalled");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_row != '0 && m_out_col != '0)
        else $error("border position emitted");
endmodule
